// ===== rtl/sslsw_pkg.sv =====
// Shared types, codes, constants and the segment map of the serial segment LCD writer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package sslsw_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int ADDR_WIDTH_DEF = 6;
	localparam int CLEAR_BITS_DEF = 38;

	// Fixed field widths of the request channel.
	localparam int NIB_ADDR_W = 6;
	localparam int NIB_DATA_W = 4;

	// Depth of the job queue between the front and the back part.
	localparam int QUEUE_DEPTH = 2;

	// Tail segment of a frame: at most nine bits (command byte plus repeated bit 0).
	localparam int TAIL_W     = 9;
	localparam int TAIL_CNT_W = 4;

	localparam logic [TAIL_CNT_W-1:0] TAIL_LEN_BYTE   = 4'd8;
	localparam logic [TAIL_CNT_W-1:0] TAIL_LEN_CMD    = 4'd9;
	localparam logic [TAIL_CNT_W-1:0] TAIL_LEN_NIBBLE = 4'd4;

	// Frame ID bits, sent MSB first.
	localparam logic [2:0] ID_DATA = 3'b101;
	localparam logic [2:0] ID_CMD  = 3'b100;
	localparam logic [1:0] ID_LEN  = 2'd3;

	// Request types.
	localparam logic [1:0] REQ_CHAR   = 2'd0;
	localparam logic [1:0] REQ_CMD    = 2'd1;
	localparam logic [1:0] REQ_NIBBLE = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_UNDER = 8'h5F;
	localparam logic [7:0] CHAR_LO_D  = 8'h64;
	localparam logic [7:0] CHAR_UP_E  = 8'h45;
	localparam logic [7:0] CHAR_LO_T  = 8'h74;
	localparam logic [7:0] CHAR_LO_F  = 8'h66;
	localparam logic [7:0] CHAR_UP_P  = 8'h50;
	localparam logic [7:0] CHAR_LO_O  = 8'h6F;
	localparam logic [7:0] CHAR_LO_U  = 8'h75;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_LO_C  = 8'h63;

	// Segment bit that lights the dot (also used for the colon).
	localparam logic [7:0] DOT_SEG = 8'h08;

	localparam logic [7:0] DIGIT_SEG [10] = '{
		8'hD7, 8'h50, 8'hB5, 8'hF1, 8'h72, 8'hE3, 8'hE7, 8'h51, 8'hF7, 8'hF3
	};

	typedef struct packed {
		logic [1:0]            req_type;
		logic [7:0]            char_code;
		logic                  is_last_char;
		logic                  colon_on;
		logic [NIB_ADDR_W-1:0] nibble_addr;
		logic [NIB_DATA_W-1:0] nibble_data;
	} req_t;

	typedef struct packed {
		logic data_bit;
		logic frame_end;
		logic run_last;
		logic rejected;
	} res_t;

	typedef enum logic [2:0] {
		KIND_REJECT = 3'd0,
		KIND_STRING = 3'd1,
		KIND_CMD    = 3'd2,
		KIND_NIBBLE = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	// One classified request as the back part carries it out.
	typedef struct packed {
		kind_t                 kind;
		logic                  hdr;      // string: send ID and zero address first
		logic                  body;     // string: send the segment byte
		logic                  close;    // string: release chip select at the end
		logic [7:0]            byte_val; // segment byte or command byte
		logic [NIB_ADDR_W-1:0] addr;
		logic [NIB_DATA_W-1:0] nib;
	} job_t;

	function automatic logic [7:0] seg_code(input logic [7:0] c);
		logic [7:0] s;
		s = c;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			s = DIGIT_SEG[c[3:0]];
		end else begin
			unique case (c)
				CHAR_DASH:  s = 8'h20;
				CHAR_UNDER: s = 8'h80;
				CHAR_LO_D:  s = 8'hF4;
				CHAR_UP_E:  s = 8'hA7;
				CHAR_LO_T:  s = 8'hA6;
				CHAR_LO_F:  s = 8'h28;
				CHAR_UP_P:  s = 8'h37;
				CHAR_LO_O:  s = 8'hE4;
				CHAR_LO_U:  s = 8'hC4;
				CHAR_UP_A:  s = 8'h77;
				CHAR_LO_C:  s = 8'h87;
				default:    s = c;
			endcase
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sslsw_ifs.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on sslsw_pkg for the payload types.
`default_nettype none

interface sslsw_req_if;
	logic              valid;
	logic              ready;
	sslsw_pkg::req_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sslsw_res_if;
	logic              valid;
	logic              ready;
	sslsw_pkg::res_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sslsw_front.sv =====
// Front part: accepts requests, tracks the string frame state and classifies
// each request into a job. Depends on sslsw_pkg and sslsw_req_if.
`default_nettype none

module sslsw_front (
	input  wire              clk,
	input  wire              arst_n,
	sslsw_req_if.sink        req,
	output logic             job_valid,
	output sslsw_pkg::job_t  job,
	input  wire              job_ready
);

	logic frame_open_q, dot_pending_q, at_start_q;
	logic frame_open_d, dot_pending_d, at_start_d;
	logic accept, push;
	logic [7:0] seg;

	assign req.ready = job_ready;
	assign accept    = req.valid && job_ready;
	assign job_valid = accept && push;

	always_comb begin
		frame_open_d  = frame_open_q;
		dot_pending_d = dot_pending_q;
		at_start_d    = at_start_q;
		push          = 1'b1;
		seg           = 8'h00;
		job.kind      = sslsw_pkg::KIND_REJECT;
		job.hdr       = 1'b0;
		job.body      = 1'b0;
		job.close     = 1'b1;
		job.byte_val  = req.payload.char_code;
		job.addr      = req.payload.nibble_addr;
		job.nib       = req.payload.nibble_data;

		if (req.payload.req_type == sslsw_pkg::REQ_CHAR) begin
			job.kind     = sslsw_pkg::KIND_STRING;
			job.hdr      = !frame_open_q;
			job.close    = req.payload.is_last_char;
			frame_open_d = 1'b1;
			at_start_d   = 1'b0;
			if (req.payload.char_code == sslsw_pkg::CHAR_DOT && !req.payload.is_last_char) begin
				// A dot only marks the next character; the frame may still open.
				dot_pending_d = 1'b1;
				push          = !frame_open_q;
			end else begin
				if (req.payload.char_code == sslsw_pkg::CHAR_DOT) begin
					seg = sslsw_pkg::DOT_SEG;
				end else begin
					seg = sslsw_pkg::seg_code(req.payload.char_code);
					if (at_start_q && req.payload.colon_on) begin
						seg = seg | sslsw_pkg::DOT_SEG;
					end
				end
				if (dot_pending_q) begin
					seg = seg | sslsw_pkg::DOT_SEG;
				end
				dot_pending_d = 1'b0;
				job.body      = 1'b1;
				job.byte_val  = seg;
				if (req.payload.is_last_char) begin
					frame_open_d = 1'b0;
					at_start_d   = 1'b1;
				end
			end
		end else if (!frame_open_q) begin
			unique case (req.payload.req_type)
				sslsw_pkg::REQ_CMD:    job.kind = sslsw_pkg::KIND_CMD;
				sslsw_pkg::REQ_NIBBLE: job.kind = sslsw_pkg::KIND_NIBBLE;
				default:               job.kind = sslsw_pkg::KIND_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q  <= 1'b0;
			dot_pending_q <= 1'b0;
			at_start_q    <= 1'b1;
		end else if (accept) begin
			frame_open_q  <= frame_open_d;
			dot_pending_q <= dot_pending_d;
			at_start_q    <= at_start_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sslsw_queue.sv =====
// Short job queue that decouples the front part from the bit serializer.
// Depends on sslsw_pkg for the job type and depth; the depth is a power of two.
`default_nettype none

module sslsw_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  sslsw_pkg::job_t  in_job,
	output logic             in_ready,
	output logic             out_valid,
	output sslsw_pkg::job_t  out_job,
	input  wire              out_ready
);

	localparam int PTR_W = (sslsw_pkg::QUEUE_DEPTH > 1) ? $clog2(sslsw_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(sslsw_pkg::QUEUE_DEPTH + 1);

	sslsw_pkg::job_t  entry_q [sslsw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = count_q != CNT_W'(sslsw_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_job   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sslsw_back.sv =====
// Back part: turns one job at a time into strobed bits behind an output register.
// Depends on sslsw_pkg and sslsw_res_if.
`default_nettype none

module sslsw_back #(
	parameter int ADDR_WIDTH = sslsw_pkg::ADDR_WIDTH_DEF,
	parameter int CLEAR_BITS = sslsw_pkg::CLEAR_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              job_valid,
	input  sslsw_pkg::job_t  job,
	output logic             job_ready,
	sslsw_res_if.source      res
);

	localparam int MID_MAX = (ADDR_WIDTH > CLEAR_BITS) ? ADDR_WIDTH : CLEAR_BITS;
	localparam int MID_CW  = $clog2(MID_MAX + 1);

	// A frame is three segments: ID (MSB first), middle (MSB first), tail (LSB first).
	logic                              busy_q, rej_q, close_q;
	logic [1:0]                        id_cnt_q;
	logic [2:0]                        id_sh_q;
	logic [MID_CW-1:0]                 mid_cnt_q;
	logic [ADDR_WIDTH-1:0]             mid_sh_q;
	logic [sslsw_pkg::TAIL_CNT_W-1:0]  tail_cnt_q;
	logic [sslsw_pkg::TAIL_W-1:0]      tail_sh_q;
	logic                              out_valid_q;
	sslsw_pkg::res_t                   res_q;

	logic                              adv, in_id, in_mid, last_now, cur_bit, load;
	logic [ADDR_WIDTH+sslsw_pkg::NIB_ADDR_W-1:0] addr_ext;
	logic [7:0]                        cmd_rev;

	assign adv      = !out_valid_q || res.ready;
	assign in_id    = id_cnt_q != 2'd0;
	assign in_mid   = !in_id && (mid_cnt_q != '0);
	assign addr_ext = {{ADDR_WIDTH{1'b0}}, job.addr};

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			cmd_rev[k] = job.byte_val[7-k];
		end
	end

	always_comb begin
		if (rej_q) begin
			last_now = 1'b1;
			cur_bit  = 1'b0;
		end else if (in_id) begin
			last_now = (id_cnt_q == 2'd1) && (mid_cnt_q == '0) && (tail_cnt_q == '0);
			cur_bit  = id_sh_q[2];
		end else if (in_mid) begin
			last_now = (mid_cnt_q == MID_CW'(1)) && (tail_cnt_q == '0);
			cur_bit  = mid_sh_q[ADDR_WIDTH-1];
		end else begin
			last_now = tail_cnt_q == sslsw_pkg::TAIL_CNT_W'(1);
			cur_bit  = tail_sh_q[0];
		end
	end

	assign load      = !busy_q || (adv && last_now);
	assign job_ready = load;

	assign res.valid   = out_valid_q;
	assign res.payload = res_q;

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			res_q.data_bit  <= cur_bit;
			res_q.frame_end <= last_now && close_q && !rej_q;
			res_q.run_last  <= last_now;
			res_q.rejected  <= rej_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			rej_q       <= 1'b0;
			close_q     <= 1'b0;
			id_cnt_q    <= '0;
			id_sh_q     <= '0;
			mid_cnt_q   <= '0;
			mid_sh_q    <= '0;
			tail_cnt_q  <= '0;
			tail_sh_q   <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q     <= job_valid;
				rej_q      <= 1'b0;
				close_q    <= 1'b1;
				id_cnt_q   <= sslsw_pkg::ID_LEN;
				id_sh_q    <= sslsw_pkg::ID_DATA;
				mid_cnt_q  <= '0;
				mid_sh_q   <= '0;
				tail_cnt_q <= '0;
				tail_sh_q  <= '0;
				unique case (job.kind)
					sslsw_pkg::KIND_REJECT: begin
						rej_q    <= 1'b1;
						id_cnt_q <= '0;
					end
					sslsw_pkg::KIND_STRING: begin
						close_q    <= job.close;
						id_cnt_q   <= job.hdr ? sslsw_pkg::ID_LEN : 2'd0;
						mid_cnt_q  <= job.hdr ? MID_CW'(ADDR_WIDTH) : '0;
						tail_cnt_q <= job.body ? sslsw_pkg::TAIL_LEN_BYTE : '0;
						tail_sh_q  <= {1'b0, job.byte_val};
					end
					sslsw_pkg::KIND_CMD: begin
						id_sh_q    <= sslsw_pkg::ID_CMD;
						tail_cnt_q <= sslsw_pkg::TAIL_LEN_CMD;
						tail_sh_q  <= {job.byte_val[0], cmd_rev};
					end
					sslsw_pkg::KIND_NIBBLE: begin
						mid_cnt_q  <= MID_CW'(ADDR_WIDTH);
						mid_sh_q   <= addr_ext[ADDR_WIDTH-1:0];
						tail_cnt_q <= sslsw_pkg::TAIL_LEN_NIBBLE;
						tail_sh_q  <= sslsw_pkg::TAIL_W'(job.nib);
					end
					default: begin
						mid_cnt_q <= MID_CW'(CLEAR_BITS);
					end
				endcase
			end else if (adv) begin
				if (in_id) begin
					id_cnt_q <= id_cnt_q - 2'd1;
					id_sh_q  <= {id_sh_q[1:0], 1'b0};
				end else if (in_mid) begin
					mid_cnt_q <= mid_cnt_q - MID_CW'(1);
					mid_sh_q  <= {mid_sh_q[ADDR_WIDTH-2:0], 1'b0};
				end else begin
					tail_cnt_q <= tail_cnt_q - sslsw_pkg::TAIL_CNT_W'(1);
					tail_sh_q  <= {1'b0, tail_sh_q[sslsw_pkg::TAIL_W-1:1]};
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/seven_segment_lcd_serial_writer.sv =====
// Serial writer for a 3-wire segment LCD controller: request channel in, bit channel out.
// Instantiates sslsw_front, sslsw_queue and sslsw_back; depends on sslsw_pkg, sslsw_ifs.
//
// Use: each transfer on req is one request: a display character, a command byte,
// a nibble write or a clear. Each transfer on res is one data bit with its write
// strobe; frame_end marks the bit after which chip select is released, run_last
// the final bit that a request produces, and rejected the single marker result of
// a command, nibble write or clear that arrives while a string frame is open.
// A dot that is neither first nor last in a string produces no transfer on res.
//
// Throughput: the serializer sends one bit per cycle while res.ready stays high. A
// string character is 8 bits, the first one of a string 11 + ADDR_WIDTH; a command is 12 bits,
// a nibble write 7 + ADDR_WIDTH, a clear 3 + CLEAR_BITS, a rejection one result. The
// front accepts a new request each cycle while the two-entry job queue has room,
// so requests are taken while earlier ones are still being shifted out.
// When the serializer is idle, the first bit of a request passes through the queue
// entry, the serializer state and the output register before it is offered on res.
// Reset clears the frame state (no string open, the next character starts a
// string), empties the queue and drops any bit in flight. When the receiver
// holds res.ready low, the bit on res holds, the serializer pauses and the queue
// fills; req.ready falls once the queue is full.
`default_nettype none

module seven_segment_lcd_serial_writer #(
	parameter int ADDR_WIDTH = sslsw_pkg::ADDR_WIDTH_DEF,
	parameter int CLEAR_BITS = sslsw_pkg::CLEAR_BITS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	sslsw_req_if.sink     req,
	sslsw_res_if.source   res
);

	// Front to queue.
	logic            f_valid, f_ready;
	sslsw_pkg::job_t f_job;

	// Queue to back.
	logic            b_valid, b_ready;
	sslsw_pkg::job_t b_job;

	// The front holds the string frame state and decides what each request sends.
	sslsw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job_valid (f_valid),
		.job       (f_job),
		.job_ready (f_ready)
	);

	// The queue lets the front keep accepting while long frames are being sent.
	sslsw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_job    (f_job),
		.in_ready  (f_ready),
		.out_valid (b_valid),
		.out_job   (b_job),
		.out_ready (b_ready)
	);

	// The back shifts the frame out bit by bit into the output register.
	sslsw_back #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.CLEAR_BITS (CLEAR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job       (b_job),
		.job_ready (b_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the serial segment LCD writer: random and directed requests
// against a cycle-free prediction of the bit stream. Needs sslsw_pkg, the channel
// interfaces and the RTL of seven_segment_lcd_serial_writer.
`timescale 1ns / 1ps

module testbench;

	// Sizes handed to the block and used by the prediction.
	localparam int ADDR_W    = 6;
	localparam int CLEAR_LEN = 38;

	// Run control.
	localparam int LIMIT_NS    = 4_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20_000;
	localparam int TAIL_CYCLES = 64;
	localparam int SHOWN_ERRS  = 10;

	// Segment patterns of the digits and the dot segment, kept apart from the RTL.
	localparam logic [7:0] SEG_DIGITS [10] = '{
		8'hD7, 8'h50, 8'hB5, 8'hF1, 8'h72, 8'hE3, 8'hE7, 8'h51, 8'hF7, 8'hF3
	};
	localparam logic [7:0] SEG_DOT = 8'h08;

	// Letters with a glyph of their own; random strings draw from these often.
	localparam logic [7:0] LETTERS [11] = '{
		sslsw_pkg::CHAR_DASH, sslsw_pkg::CHAR_UNDER, sslsw_pkg::CHAR_LO_D,
		sslsw_pkg::CHAR_UP_E, sslsw_pkg::CHAR_LO_T, sslsw_pkg::CHAR_LO_F,
		sslsw_pkg::CHAR_UP_P, sslsw_pkg::CHAR_LO_O, sslsw_pkg::CHAR_LO_U,
		sslsw_pkg::CHAR_UP_A, sslsw_pkg::CHAR_LO_C
	};

	// The scoreboard predicts the bit stream of every accepted request and compares each
	// bit transfer on the result channel with the oldest bit still waiting.
	class lcd_bit_scoreboard;
		sslsw_pkg::res_t pending_bits[$];
		// Frame state as the controller sees it.
		bit   string_open;
		bit   dot_waiting;
		bit   string_start;
		int   mismatches;
		int   checked;
		int   requests;
		int   strings_closed;
		int   rejections;

		function new();
			string_open  = 1'b0;
			dot_waiting  = 1'b0;
			string_start = 1'b1;
		endfunction

		function void add_bit(logic d, logic fe);
			sslsw_pkg::res_t b;
			b           = '0;
			b.data_bit  = d;
			b.frame_end = fe;
			pending_bits.push_back(b);
		endfunction

		function void add_id(logic is_data);
			add_bit(1'b1, 1'b0);
			add_bit(1'b0, 1'b0);
			add_bit(is_data, 1'b0);
		endfunction

		// Works out the bits that one accepted request causes.
		function void note_request(sslsw_pkg::req_t r);
			sslsw_pkg::res_t b;
			logic [7:0]      seg;
			bit              first;
			int              base;
			base = pending_bits.size();
			requests++;
			// Commands, nibble writes and clears cannot cut into an open string frame.
			if (r.req_type != sslsw_pkg::REQ_CHAR && string_open) begin
				b          = '0;
				b.run_last = 1'b1;
				b.rejected = 1'b1;
				pending_bits.push_back(b);
				rejections++;
				return;
			end
			case (r.req_type)
				sslsw_pkg::REQ_CHAR: begin
					first = string_start;
					if (!string_open) begin
						add_id(1'b1);
						for (int k = 0; k < ADDR_W; k++) add_bit(1'b0, 1'b0);
						string_open = 1'b1;
					end
					string_start = 1'b0;
					if (r.char_code == sslsw_pkg::CHAR_DOT && !r.is_last_char) begin
						// A dot only marks the next character.
						dot_waiting = 1'b1;
					end else begin
						if (r.char_code == sslsw_pkg::CHAR_DOT) begin
							seg = SEG_DOT;
						end else if (r.char_code >= sslsw_pkg::CHAR_ZERO &&
						             r.char_code <= sslsw_pkg::CHAR_NINE) begin
							seg = SEG_DIGITS[r.char_code[3:0]];
						end else begin
							case (r.char_code)
								sslsw_pkg::CHAR_DASH:  seg = 8'h20;
								sslsw_pkg::CHAR_UNDER: seg = 8'h80;
								sslsw_pkg::CHAR_LO_D:  seg = 8'hF4;
								sslsw_pkg::CHAR_UP_E:  seg = 8'hA7;
								sslsw_pkg::CHAR_LO_T:  seg = 8'hA6;
								sslsw_pkg::CHAR_LO_F:  seg = 8'h28;
								sslsw_pkg::CHAR_UP_P:  seg = 8'h37;
								sslsw_pkg::CHAR_LO_O:  seg = 8'hE4;
								sslsw_pkg::CHAR_LO_U:  seg = 8'hC4;
								sslsw_pkg::CHAR_UP_A:  seg = 8'h77;
								sslsw_pkg::CHAR_LO_C:  seg = 8'h87;
								default:               seg = r.char_code;
							endcase
						end
						if (dot_waiting) seg |= SEG_DOT;
						dot_waiting = 1'b0;
						// The colon only counts on the first character of a string.
						if (first && r.colon_on && r.char_code != sslsw_pkg::CHAR_DOT) begin
							seg |= SEG_DOT;
						end
						for (int k = 0; k < 8; k++) add_bit(seg[k], r.is_last_char && k == 7);
						if (r.is_last_char) begin
							string_open  = 1'b0;
							dot_waiting  = 1'b0;
							string_start = 1'b1;
							strings_closed++;
						end
					end
				end
				sslsw_pkg::REQ_CMD: begin
					add_id(1'b0);
					for (int k = 7; k >= 0; k--) add_bit(r.char_code[k], 1'b0);
					add_bit(r.char_code[0], 1'b1);
				end
				sslsw_pkg::REQ_NIBBLE: begin
					add_id(1'b1);
					for (int k = ADDR_W - 1; k >= 0; k--) add_bit(r.nibble_addr[k], 1'b0);
					for (int k = 0; k < 4; k++) add_bit(r.nibble_data[k], k == 3);
				end
				default: begin
					add_id(1'b1);
					for (int k = 0; k < CLEAR_LEN; k++) add_bit(1'b0, k == CLEAR_LEN - 1);
				end
			endcase
			if (pending_bits.size() > base) begin
				b          = pending_bits.pop_back();
				b.run_last = 1'b1;
				pending_bits.push_back(b);
			end
		endfunction

		function void flag(string what, bit have_want, sslsw_pkg::res_t want,
			sslsw_pkg::res_t got);
			mismatches++;
			if (mismatches <= SHOWN_ERRS) begin
				if (have_want) begin
					$display("%0d ns: %s at bit %0d: expected data=%b end=%b last=%b rej=%b",
						$time, what, checked, want.data_bit, want.frame_end,
						want.run_last, want.rejected);
				end else begin
					$display("%0d ns: %s at bit %0d: nothing was waiting", $time, what, checked);
				end
				$display("    got data=%b end=%b last=%b rej=%b",
					got.data_bit, got.frame_end, got.run_last, got.rejected);
			end
		endfunction

		// Compares one result transfer with the oldest waiting bit.
		function void check_bit(sslsw_pkg::res_t got);
			sslsw_pkg::res_t want;
			checked++;
			if (pending_bits.size() == 0) begin
				flag("unexpected bit", 1'b0, '0, got);
				return;
			end
			want = pending_bits.pop_front();
			if (got.data_bit !== want.data_bit || got.frame_end !== want.frame_end ||
			    got.run_last !== want.run_last || got.rejected !== want.rejected) begin
				flag("bit mismatch", 1'b1, want, got);
			end
		endfunction

		function int pending();
			return pending_bits.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sslsw_req_if req_if();
	sslsw_res_if res_if();

	seven_segment_lcd_serial_writer #(
		.ADDR_WIDTH(ADDR_W),
		.CLEAR_BITS(CLEAR_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if)
	);

	lcd_bit_scoreboard sb;

	// Idle rates in percent of cycles for both sides; the main sequence changes them
	// phase by phase.
	int send_idle_pct = 8;
	int recv_idle_pct = 75;
	int requests_sent = 0;
	// Set by the main sequence to ask the receiver for one long hold-off.
	bit stall_armed = 1'b0;
	int hold_left = 0;

	always #4 clk = ~clk;

	// A request with every field random; the makers below fix the fields that matter,
	// so unused fields still toggle on every bit.
	function automatic sslsw_pkg::req_t noise_request();
		logic [31:0]     raw;
		sslsw_pkg::req_t r;
		raw = $urandom;
		r   = raw[$bits(sslsw_pkg::req_t)-1:0];
		return r;
	endfunction

	function automatic sslsw_pkg::req_t make_char(logic [7:0] code, logic last, logic colon);
		sslsw_pkg::req_t r;
		r              = noise_request();
		r.req_type     = sslsw_pkg::REQ_CHAR;
		r.char_code    = code;
		r.is_last_char = last;
		r.colon_on     = colon;
		return r;
	endfunction

	function automatic sslsw_pkg::req_t make_cmd(logic [7:0] code);
		sslsw_pkg::req_t r;
		r           = noise_request();
		r.req_type  = sslsw_pkg::REQ_CMD;
		r.char_code = code;
		return r;
	endfunction

	function automatic sslsw_pkg::req_t make_nibble(logic [5:0] addr, logic [3:0] data);
		sslsw_pkg::req_t r;
		r             = noise_request();
		r.req_type    = sslsw_pkg::REQ_NIBBLE;
		r.nibble_addr = addr;
		r.nibble_data = data;
		return r;
	endfunction

	function automatic sslsw_pkg::req_t make_clear();
		sslsw_pkg::req_t r;
		r          = noise_request();
		r.req_type = sslsw_pkg::REQ_CLEAR;
		return r;
	endfunction

	// A frame of its own: command, nibble write or the longer clear, less often.
	function automatic sslsw_pkg::req_t make_frame_request();
		int          sel;
		logic [31:0] raw;
		sel = $urandom_range(99);
		raw = $urandom;
		if (sel < 45) return make_cmd(raw[7:0]);
		if (sel < 85) return make_nibble(raw[13:8], raw[19:16]);
		return make_clear();
	endfunction

	// Offers one request, idling first at the current rate, and hands it to the
	// scoreboard at the edge where the transfer happens. Valid stays high on return,
	// so the next call or a drain decides what the next cycle looks like.
	task automatic send_request(input sslsw_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid   <= 1'b0;
			req_if.payload <= noise_request();
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= item;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		sb.note_request(item);
		requests_sent++;
	endtask

	// Stops offering and waits until every predicted bit has come back.
	task automatic drain_results();
		int waited;
		waited = 0;
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Mostly well-formed strings of random characters, with commands, nibble writes
	// and clears in between. Some frame requests land inside a string and must be
	// rejected; a few fully random requests break strings open at odd points.
	task automatic random_requests(input int count);
		int          target;
		int          sel;
		int          len;
		logic [7:0]  code;
		logic [31:0] raw;
		target = requests_sent + count;
		while (requests_sent < target) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
				for (int i = 0; i < len; i++) begin
					sel = $urandom_range(99);
					raw = $urandom;
					if (sel < 40) begin
						code = sslsw_pkg::CHAR_ZERO + 8'(raw[31:4] % 10);
					end else if (sel < 65) begin
						code = LETTERS[raw[31:4] % 11];
					end else if (sel < 75) begin
						code = sslsw_pkg::CHAR_DOT;
					end else begin
						code = raw[7:0];
					end
					send_request(make_char(code, i == len - 1, raw[3]));
					if (i != len - 1 && $urandom_range(99) < 12) begin
						send_request(make_frame_request());
					end
				end
			end else if (sel < 92) begin
				send_request(make_frame_request());
			end else begin
				send_request(noise_request());
			end
		end
	endtask

	// Receiver: takes bits at the current idle rate, or holds ready low for a long
	// stretch when asked, counting the cycles itself. The sender keeps offering
	// meanwhile, so the job queue fills and the request channel stalls.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_armed) begin
				stall_armed = 1'b0;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every result transfer goes to the scoreboard. Values are read right after the
	// edge, before any update of that edge lands, so they are the ones the block saw.
	initial begin
		forever begin
			@(posedge clk);
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				sb.check_bit(res_if.payload);
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Run timed out after %0d ns with %0d bits still expected",
			LIMIT_NS, sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sb             = new();
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		arst_n         = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: a lazy receiver, a busy sender. The directed requests come first:
		// field extremes of commands and nibble writes, and a clear.
		send_request(make_cmd(8'h00));
		send_request(make_cmd(8'hFF));
		send_request(make_nibble(6'd0, 4'd0));
		send_request(make_nibble(6'd63, 4'd15));
		send_request(make_clear());
		// A dot that opens a string sends only the header and swallows the colon; the
		// next character gets the dot. Two dots in a row, the second one closing the
		// string, send a blank character with the dot lit.
		send_request(make_char(sslsw_pkg::CHAR_DOT, 1'b0, 1'b1));
		send_request(make_char(sslsw_pkg::CHAR_ZERO + 8'd8, 1'b0, 1'b0));
		send_request(make_char(sslsw_pkg::CHAR_DOT, 1'b0, 1'b0));
		send_request(make_char(sslsw_pkg::CHAR_DOT, 1'b1, 1'b0));
		// Colon on the first character counts, on a later one it does not. Frame
		// requests inside the open string are rejected, and an unmapped code goes out raw.
		send_request(make_char(sslsw_pkg::CHAR_UP_A, 1'b0, 1'b1));
		send_request(make_cmd(8'hA5));
		send_request(make_nibble(6'd21, 4'd10));
		send_request(make_clear());
		send_request(make_char(sslsw_pkg::CHAR_UP_E, 1'b0, 1'b1));
		send_request(make_char(8'hFF, 1'b1, 1'b0));
		// All ten digits in one string, then a string that is a single dot.
		for (int d = 0; d < 10; d++) begin
			send_request(make_char(sslsw_pkg::CHAR_ZERO + 8'(d), d == 9, 1'b0));
		end
		send_request(make_char(sslsw_pkg::CHAR_DOT, 1'b1, 1'b1));
		random_requests(85);

		// The sender pauses until the block has sent everything, then phase two swaps
		// the idle rates.
		drain_results();
		send_idle_pct = 75;
		recv_idle_pct = 8;
		random_requests(85);
		drain_results();

		// Phase three: nobody idles, except for one long hold-off of the receiver.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_armed   = 1'b1;
		random_requests(85);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d expected bits never arrived", sb.pending());
			sb.mismatches += sb.pending();
		end

		$display("Covered %0d requests: %0d strings closed, %0d rejected, %0d bits checked.",
			sb.requests, sb.strings_closed, sb.rejections, sb.checked);
		$display("Idle mixes: lazy receiver, lazy sender, none; one %0d-cycle receiver hold-off.",
			HOLD_CYCLES);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
